// ===== rtl/lqsms_pkg.sv =====
// Shared types and constants for the bounded key store (queue / stack / extract-min).
// Transaction structs, operation and status codes, controller-datapath command and status.
// No dependencies.
package lqsms_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_WIDTH_DEF = 16;
    localparam int VALUE_W       = 16;
    localparam int OCC_W         = 5;

    typedef enum logic [1:0] {
        OP_PUSH       = 2'd0,
        OP_POP_OLDEST = 2'd1,
        OP_POP_NEWEST = 2'd2,
        OP_POP_MIN    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [VALUE_W-1:0] entry_value;
    } cmd_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] removed_value;
        logic [1:0]         status;
        logic               now_empty;
        logic [OCC_W-1:0]   occupancy;
    } res_item_t;

    // controller -> datapath
    typedef struct packed {
        logic    load_item;
        logic    push_write;
        logic    rd_oldest;
        logic    rd_newest;
        logic    scan_start;
        logic    scan_step;
        logic    shift_start;
        logic    shift_step;
        logic    count_dec;
        logic    res_set;
        logic    res_from_rd;
        logic    res_load;
        status_t res_code;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic is_empty;
        logic is_full;
        logic idx_zero;
        logic idx_last;
        logic best_last;
        logic res_free;
    } dp_sts_t;

endpackage

// ===== rtl/lqsms_ctrl.sv =====
// Sequencing state machine for the key store.
// Depends on lqsms_pkg; drives dp_cmd_t into lqsms_dpath, reads dp_sts_t back.
module lqsms_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  lqsms_pkg::dp_sts_t sts,
    output lqsms_pkg::dp_cmd_t cmd
);
    import lqsms_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DECODE  = 7'b0000010,
        S_READ    = 7'b0000100,
        S_SCAN    = 7'b0001000,
        S_SHSTART = 7'b0010000,
        S_SHIFT   = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.res_code = ST_OK;
        state_next   = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.res_set = 1'b1;
                state_next  = S_DONE;
                case (sts.op)
                    OP_PUSH:
                    begin
                        if (sts.is_full)
                        begin
                            cmd.res_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.push_write = 1'b1;
                        end
                    end
                    OP_POP_OLDEST:
                    begin
                        if (sts.is_empty)
                        begin
                            cmd.res_code = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_oldest = 1'b1;
                            state_next    = S_READ;
                        end
                    end
                    OP_POP_NEWEST:
                    begin
                        if (sts.is_empty)
                        begin
                            cmd.res_code = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_newest = 1'b1;
                            state_next    = S_READ;
                        end
                    end
                    OP_POP_MIN:
                    begin
                        if (sts.is_empty)
                        begin
                            cmd.res_code = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.res_from_rd = 1'b1;
                state_next      = S_DONE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.idx_zero)
                begin
                    state_next = S_SHSTART;
                end
            end
            S_SHSTART:
            begin
                // newest entry was the minimum: nothing to close up
                if (sts.best_last)
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.shift_start = 1'b1;
                    state_next      = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.res_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lqsms_dpath.sv =====
// Datapath of the key store: circular entry memory, head/count, scan and close-up logic,
// result register. Depends on lqsms_pkg; steered by lqsms_ctrl.
module lqsms_dpath #(
    parameter int CAPACITY  = lqsms_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = lqsms_pkg::KEY_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lqsms_pkg::dp_cmd_t   cmd,
    output lqsms_pkg::dp_sts_t   sts,
    input  lqsms_pkg::cmd_item_t cmd_item,
    output logic                 res_valid,
    input  logic                 res_stall,
    output lqsms_pkg::res_item_t res_item
);
    import lqsms_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int PW     = ADDR_W + 1;

    logic [KEY_WIDTH-1:0] mem [CAPACITY];

    logic [ADDR_W-1:0]    head_reg;
    logic [ADDR_W-1:0]    head_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    op_t                  op_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [ADDR_W-1:0]    idx_reg;
    logic [ADDR_W-1:0]    best_reg;
    logic [KEY_WIDTH-1:0] rd_data_reg;
    logic [KEY_WIDTH-1:0] res_key_reg;
    status_t              res_status_reg;
    logic                 res_valid_reg;
    res_item_t            res_item_reg;

    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_lg;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_lg;
    logic [ADDR_W-1:0]    wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;
    logic [ADDR_W-1:0]    last_lg;
    logic                 idx_zero;
    logic                 idx_last;
    logic                 best_last;
    logic                 is_full;
    logic                 res_free;
    logic                 take_min;

    // logical position (0 = oldest) to memory address
    function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] head,
                                               input logic [ADDR_W-1:0] lg);
        logic [PW-1:0] s;
        s = PW'(head) + PW'(lg);
        if (s >= PW'(CAPACITY))
        begin
            s = s - PW'(CAPACITY);
        end
        return s[ADDR_W-1:0];
    endfunction

    assign last_lg   = ADDR_W'(count_reg - CNT_W'(1));
    assign idx_zero  = (idx_reg == '0);
    assign idx_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign best_last = ((CNT_W'(best_reg) + CNT_W'(1)) == count_reg);
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign res_free  = !res_valid_reg || !res_stall;

    assign sts.op        = op_reg;
    assign sts.is_empty  = (count_reg == '0);
    assign sts.is_full   = is_full;
    assign sts.idx_zero  = idx_zero;
    assign sts.idx_last  = idx_last;
    assign sts.best_last = best_last;
    assign sts.res_free  = res_free;

    // read port address select
    always_comb
    begin
        rd_en = 1'b0;
        rd_lg = '0;
        if (cmd.rd_oldest)
        begin
            rd_en = 1'b1;
        end
        else if (cmd.rd_newest || cmd.scan_start)
        begin
            rd_en = 1'b1;
            rd_lg = last_lg;
        end
        else if (cmd.scan_step && !idx_zero)
        begin
            rd_en = 1'b1;
            rd_lg = idx_reg - ADDR_W'(1);
        end
        else if (cmd.shift_start)
        begin
            rd_en = 1'b1;
            rd_lg = best_reg + ADDR_W'(1);
        end
        else if (cmd.shift_step && !idx_last)
        begin
            rd_en = 1'b1;
            rd_lg = idx_reg + ADDR_W'(1);
        end
    end

    assign rd_addr = phys(head_reg, rd_lg);

    // write port: push appends, close-up moves entry idx down to idx-1
    always_comb
    begin
        wr_en   = cmd.push_write | cmd.shift_step;
        wr_lg   = cmd.push_write ? ADDR_W'(count_reg) : (idx_reg - ADDR_W'(1));
        wr_data = cmd.push_write ? key_reg : rd_data_reg;
    end

    assign wr_addr = phys(head_reg, wr_lg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // head and occupancy
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.rd_oldest)
        begin
            head_next = (head_reg == ADDR_W'(CAPACITY - 1)) ? '0 : head_reg + ADDR_W'(1);
        end
        if (cmd.push_write)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.rd_oldest || cmd.rd_newest || cmd.count_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cmd.res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // first entry seen seeds the minimum; strict compare keeps the newest of equals
    assign take_min = idx_last || (rd_data_reg < res_key_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg  <= op_t'(cmd_item.operation);
            key_reg <= KEY_WIDTH'(cmd_item.entry_value);
        end
        if (cmd.scan_start)
        begin
            idx_reg <= last_lg;
        end
        else if (cmd.scan_step && !idx_zero)
        begin
            idx_reg <= idx_reg - ADDR_W'(1);
        end
        else if (cmd.shift_start)
        begin
            idx_reg <= best_reg + ADDR_W'(1);
        end
        else if (cmd.shift_step && !idx_last)
        begin
            idx_reg <= idx_reg + ADDR_W'(1);
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_code;
            res_key_reg    <= '0;
        end
        else if (cmd.res_from_rd)
        begin
            res_key_reg <= rd_data_reg;
        end
        else if (cmd.scan_step && take_min)
        begin
            res_key_reg <= rd_data_reg;
            best_reg    <= idx_reg;
        end
        if (cmd.res_load)
        begin
            res_item_reg.removed_value <= VALUE_W'(res_key_reg);
            res_item_reg.status        <= res_status_reg;
            res_item_reg.now_empty     <= (count_reg == '0);
            res_item_reg.occupancy     <= OCC_W'(count_reg);
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("close-up read and write hit one address");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_write |-> !is_full)
        else $error("write into a full store");

    a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_load && res_status_reg == ST_FULL) |-> is_full)
        else $error("full reported with room left");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_oldest || cmd.rd_newest || cmd.count_dec) |=>
            (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not reduce occupancy by one");
`endif

endmodule

// ===== rtl/list_queue_stack_min_store.sv =====
// Top level of the bounded key store: queue, stack and extract-min in one block.
// Depends on lqsms_pkg; instantiates lqsms_ctrl and lqsms_dpath.
//
//   channel | handshake            | payload              | direction
//   --------+----------------------+----------------------+----------
//   command | cmd_valid, cmd_stall | cmd_item (cmd_item_t) | into block
//   result  | res_valid, res_stall | res_item (res_item_t) | out of block
//
// Pop-min uses the one read port to walk all held entries once to find the minimum, then
//   to walk the entries newer than the removed key to close the gap.
// Reset clears head, occupancy, result valid and the state machine, not the entry memory.
// A command is taken whenever the controller is idle, even while the previous result
//   waits on res_stall; its own result then holds until the result register frees.
module list_queue_stack_min_store #(
    parameter int CAPACITY  = lqsms_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = lqsms_pkg::KEY_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  lqsms_pkg::cmd_item_t cmd_item,
    output logic                 res_valid,
    input  logic                 res_stall,
    output lqsms_pkg::res_item_t res_item
);
    import lqsms_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    // sequencing: one transaction at a time
    lqsms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    // storage, scan compare and result register
    lqsms_dpath #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .sts       (dp_sts),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule
